@@ hdl/b64_pkg.sv @@
// shared types, constants and character mapping functions of the base64 codec
// no dependencies
package b64_pkg;

    localparam logic [7:0] C_PAD = 8'h3d;  // '='
    localparam logic [7:0] C_UPPER_A = 8'h41;
    localparam logic [7:0] C_UPPER_Z = 8'h5a;
    localparam logic [7:0] C_LOWER_A = 8'h61;
    localparam logic [7:0] C_LOWER_Z = 8'h7a;
    localparam logic [7:0] C_DIGIT_0 = 8'h30;
    localparam logic [7:0] C_DIGIT_9 = 8'h39;
    localparam logic [7:0] C_PLUS = 8'h2b;
    localparam logic [7:0] C_SLASH = 8'h2f;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // one group worth of results, handed from the group stage to the output stage
    typedef struct packed {
        logic            valid;
        logic [2:0]      count;
        logic [3:0][7:0] data;
        logic [3:0]      last;
    } t_burst;

    // 6-bit index to alphabet character
    function automatic logic [7:0] char_of(input logic [5:0] idx);
        logic [7:0] v;
        v = {2'b00, idx};
        if (idx < 6'd26) begin
            char_of = C_UPPER_A + v;
        end else if (idx < 6'd52) begin
            char_of = C_LOWER_A + v - 8'd26;
        end else if (idx < 6'd62) begin
            char_of = C_DIGIT_0 + v - 8'd52;
        end else if (idx == 6'd62) begin
            char_of = C_PLUS;
        end else begin
            char_of = C_SLASH;
        end
    endfunction

    // character to 6-bit value, anything outside the alphabet gives 0
    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= C_UPPER_A && c <= C_UPPER_Z) begin
            v = c - C_UPPER_A;
        end else if (c >= C_LOWER_A && c <= C_LOWER_Z) begin
            v = c - C_LOWER_A + 8'd26;
        end else if (c >= C_DIGIT_0 && c <= C_DIGIT_9) begin
            v = c - C_DIGIT_0 + 8'd52;
        end else if (c == C_PLUS) begin
            v = 8'd62;
        end else if (c == C_SLASH) begin
            v = 8'd63;
        end
        sextet_of = v[5:0];
    endfunction

endpackage

@@ hdl/b64_in_if.sv @@
// input item channel of the base64 codec
// no dependencies
interface b64_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

@@ hdl/b64_out_if.sv @@
// result item channel of the base64 codec
// no dependencies
interface b64_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

@@ hdl/b64_cfg_if.sv @@
// direction register write channel of the base64 codec
// no dependencies
interface b64_cfg_if;
    logic valid;
    logic ready;
    logic direction;

    modport source (output valid, output direction, input ready);
    modport sink (input valid, input direction, output ready);
endinterface

@@ hdl/base64_codec_top.sv @@
// base64 codec top level (standard alphabet), encode or decode by direction
// depends on b64_pkg, b64_in_if, b64_out_if, b64_cfg_if, b64_group, b64_drain
// path: an item passes the input register, then the burst register of its group
//   and the result register; results come one per cycle while the output is ready
// throughput: decoding whole groups takes one item per cycle while the output is
//   ready; encoding is bound by the output port, 4 results per 3 bytes
// reset: synchronous active low, clears direction to encode and the group
module base64_codec_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    b64_in_if.sink    i_in,
    b64_cfg_if.sink   i_cfg,
    b64_out_if.source o_out
);
    import b64_pkg::*;

    t_burst burst;   // one group of results, registered in the group stage
    logic   free;    // result register can take a new burst this cycle

    // input register plus group collector; a write to the direction register
    // also drops any partial group
    b64_group u_group (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_free  (free),
        .o_burst (burst)
    );

    // result register, shifts out up to four results per group
    b64_drain u_drain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_burst (burst),
        .o_free  (free),
        .o_out   (o_out)
    );

endmodule

@@ hdl/b64_group.sv @@
// input register and group collector, builds one burst of results per group
// depends on b64_pkg, b64_in_if, b64_cfg_if
module b64_group (
    input  logic            i_clk,
    input  logic            i_rst_n,
    b64_in_if.sink          i_in,
    b64_cfg_if.sink         i_cfg,
    input  logic            i_free,
    output b64_pkg::t_burst o_burst
);
    import b64_pkg::*;

    logic        r_dir;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic [23:0] r_bits;
    logic [1:0]  r_cnt;
    logic [1:0]  r_pad;

    logic        n_dir;
    logic [23:0] n_bits;
    logic [1:0]  n_pad;
    logic        done;
    logic        step;
    logic        cfg_wr;
    logic [5:0]  sext;
    logic [1:0]  pad_min;
    t_burst      n_burst;
    t_burst      r_burst;

    assign cfg_wr = i_cfg.valid;
    assign i_cfg.ready = 1'b1;
    assign n_dir = cfg_wr ? i_cfg.direction : r_dir;

    assign done = (r_dir == DIR_ENCODE) ? (r_cnt == 2'd2 || r_in_last)
                                        : (r_cnt == 2'd3 || r_in_last);
    assign step = r_in_valid && (!done || i_free);
    assign i_in.ready = !r_in_valid || step;
    assign sext = sextet_of(r_in_byte);

    always_comb begin
        n_bits = r_bits;
        n_pad = 2'd0;
        if (r_dir == DIR_ENCODE) begin
            case (r_cnt)
                2'd0: n_bits[23:16] = r_in_byte;
                2'd1: n_bits[15:8] = r_in_byte;
                default: n_bits[7:0] = r_in_byte;
            endcase
        end else begin
            case (r_cnt)
                2'd0: n_bits[23:18] = sext;
                2'd1: n_bits[17:12] = sext;
                2'd2: n_bits[11:6] = sext;
                default: n_bits[5:0] = sext;
            endcase
            if (r_in_byte == C_PAD) begin
                n_pad = (r_pad == 2'd3) ? 2'd3 : r_pad + 2'd1;
            end
        end
    end

    assign pad_min = (n_pad == 2'd3) ? 2'd2 : n_pad;

    always_comb begin
        n_burst = '0;
        n_burst.valid = 1'b1;
        if (r_dir == DIR_ENCODE) begin
            n_burst.count = 3'd4;
            for (int k = 0; k < 4; k++) begin
                if (3'(k) >= {1'b0, r_cnt} + 3'd2) begin
                    n_burst.data[k] = C_PAD;
                end else begin
                    n_burst.data[k] = char_of(n_bits[23 - 6 * k -: 6]);
                end
            end
            n_burst.last[3] = r_in_last;
        end else begin
            if (r_cnt == 2'd3) begin
                n_burst.count = r_in_last ? 3'd3 - {1'b0, pad_min} : 3'd3;
            end else begin
                n_burst.count = {1'b0, r_cnt};
            end
            for (int k = 0; k < 3; k++) begin
                n_burst.data[k] = n_bits[23 - 8 * k -: 8];
                n_burst.last[k] = r_in_last && (3'(k) + 3'd1 == n_burst.count);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= DIR_ENCODE;
            r_in_valid <= 1'b0;
            r_bits <= '0;
            r_cnt <= '0;
            r_pad <= '0;
            r_burst <= '0;
        end else begin
            r_dir <= n_dir;
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            r_burst.valid <= step && done;
            if (step && done) begin
                r_burst.count <= n_burst.count;
                r_burst.data <= n_burst.data;
                r_burst.last <= n_burst.last;
            end
            if (cfg_wr) begin
                r_bits <= '0;
                r_cnt <= '0;
                r_pad <= '0;
            end else if (step) begin
                if (done) begin
                    r_bits <= '0;
                    r_cnt <= '0;
                    r_pad <= '0;
                end else begin
                    r_bits <= n_bits;
                    r_cnt <= r_cnt + 2'd1;
                    r_pad <= n_pad;
                end
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.in_last;
        end
    end

    assign o_burst = r_burst;

endmodule

@@ hdl/b64_drain.sv @@
// result register, sends the results of one burst one per cycle while the output is ready
// depends on b64_pkg, b64_out_if
module b64_drain (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  b64_pkg::t_burst i_burst,
    output logic            o_free,
    b64_out_if.source       o_out
);
    import b64_pkg::*;

    logic [2:0]      r_rem;
    logic [3:0][7:0] r_data;
    logic [3:0]      r_last;
    logic            take;

    assign take = o_out.valid && o_out.ready;
    // a burst still on its way in counts as occupying the register
    assign o_free = !i_burst.valid &&
                    ((r_rem == 3'd0) || (r_rem == 3'd1 && o_out.ready));

    assign o_out.valid = (r_rem != 3'd0);
    assign o_out.out_byte = r_data[0];
    assign o_out.out_last = r_last[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_burst.valid) begin
            r_rem <= i_burst.count;
        end else if (take) begin
            r_rem <= r_rem - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_burst.valid) begin
            r_data <= i_burst.data;
            r_last <= i_burst.last;
        end else if (take) begin
            r_data <= {8'h00, r_data[3:1]};
            r_last <= {1'b0, r_last[3:1]};
        end
    end

endmodule
